>>> rtl/tftp_session_sequencer_core_macros.svh
`ifndef TFTP_SESSION_SEQUENCER_CORE_MACROS_SVH
`define TFTP_SESSION_SEQUENCER_CORE_MACROS_SVH

// Antecedent and consequent hold in the same cycle.
`define TSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tss_pkg.sv
package tss_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned LEN_W       = 10;
    localparam int unsigned BLK_W       = 16;

    localparam logic [LEN_W-1:0] BLOCK_LEN  = LEN_W'(BLOCK_BYTES);
    localparam logic [LEN_W-1:0] HDR_LEN    = LEN_W'(4);
    localparam logic [LEN_W-1:0] ERR_LEN    = LEN_W'(28);
    localparam logic [BLK_W-1:0] ERR_ILLEGAL = BLK_W'(4);

    // Item kinds.
    localparam logic [1:0] KIND_OPEN_READ  = 2'd0;
    localparam logic [1:0] KIND_OPEN_WRITE = 2'd1;
    localparam logic [1:0] KIND_PACKET     = 2'd2;
    localparam logic [1:0] KIND_TICK       = 2'd3;

    // Received opcodes.
    localparam logic [15:0] RX_RRQ   = 16'd1;
    localparam logic [15:0] RX_WRQ   = 16'd2;
    localparam logic [15:0] RX_DATA  = 16'd3;
    localparam logic [15:0] RX_ACK   = 16'd4;
    localparam logic [15:0] RX_ERROR = 16'd5;

    // Transmitted opcodes.
    localparam logic [2:0] TX_NONE  = 3'd0;
    localparam logic [2:0] TX_DATA  = 3'd3;
    localparam logic [2:0] TX_ACK   = 3'd4;
    localparam logic [2:0] TX_ERROR = 3'd5;

    // Session modes.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Session end codes.
    localparam logic [1:0] END_NONE  = 2'd0;
    localparam logic [1:0] END_DONE  = 2'd1;
    localparam logic [1:0] END_ABORT = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      opcode;
        logic [BLK_W-1:0] block_number;
        logic [LEN_W-1:0] packet_len;
        logic [LEN_W-1:0] chunk_len;
    } tss_item_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [BLK_W-1:0] block_count;
        logic             file_ended;
        logic [LEN_W-1:0] last_len;
        logic [15:0]      elapsed;
    } tss_state_t;

    typedef struct packed {
        logic             send;
        logic [2:0]       out_opcode;
        logic [BLK_W-1:0] out_block;
        logic [LEN_W-1:0] out_len;
        logic             store_valid;
        logic [LEN_W-1:0] store_len;
        logic             chunk_taken;
        logic [1:0]       session_end;
    } tss_result_t;

endpackage

>>> rtl/tss_step.sv
module tss_step
    import tss_pkg::*;
(
    input  tss_state_t  state,
    input  tss_item_t   item,
    input  logic [15:0] timeout,
    output tss_state_t  state_next,
    output logic        res_valid,
    output tss_result_t res
);

    logic [LEN_W-1:0] chunk_clamped;
    logic [LEN_W-1:0] pay_raw;
    logic [LEN_W-1:0] payload;
    logic [15:0]      elapsed_inc;
    logic [15:0]      limit;
    logic [BLK_W-1:0] block_inc;

    assign chunk_clamped = (item.chunk_len > BLOCK_LEN) ? BLOCK_LEN : item.chunk_len;
    assign pay_raw       = item.packet_len - HDR_LEN;
    assign payload       = (item.packet_len < HDR_LEN) ? '0 :
                           ((pay_raw > BLOCK_LEN) ? BLOCK_LEN : pay_raw);
    assign elapsed_inc   = (state.elapsed == 16'hFFFF) ? state.elapsed
                                                        : state.elapsed + 16'd1;
    assign limit         = (timeout == 16'd0) ? 16'd1 : timeout;
    assign block_inc     = state.block_count + BLK_W'(1);

    always_comb
    begin
        state_next = state;
        res_valid  = 1'b0;
        res        = '0;

        unique case (item.kind)
            KIND_OPEN_READ:
            begin
                state_next.mode        = MODE_READ;
                state_next.block_count = BLK_W'(1);
                state_next.file_ended  = (chunk_clamped < BLOCK_LEN);
                state_next.last_len    = HDR_LEN + chunk_clamped;
                state_next.elapsed     = '0;
                res_valid              = 1'b1;
                res.send               = 1'b1;
                res.out_opcode         = TX_DATA;
                res.out_block          = BLK_W'(1);
                res.out_len            = HDR_LEN + chunk_clamped;
                res.chunk_taken        = 1'b1;
            end
            KIND_OPEN_WRITE:
            begin
                state_next.mode        = MODE_WRITE;
                state_next.block_count = '0;
                state_next.file_ended  = 1'b0;
                state_next.last_len    = HDR_LEN;
                state_next.elapsed     = '0;
                res_valid              = 1'b1;
                res.send               = 1'b1;
                res.out_opcode         = TX_ACK;
                res.out_len            = HDR_LEN;
            end
            KIND_TICK:
            begin
                if (state.mode != MODE_IDLE)
                begin
                    if (elapsed_inc < limit)
                    begin
                        state_next.elapsed = elapsed_inc;
                    end
                    else
                    begin
                        // Timeout: resend the last packet of this session.
                        state_next.elapsed = '0;
                        res_valid          = 1'b1;
                        res.send           = 1'b1;
                        res.out_opcode     = (state.mode == MODE_READ) ? TX_DATA : TX_ACK;
                        res.out_block      = state.block_count;
                        res.out_len        = state.last_len;
                    end
                end
            end
            KIND_PACKET:
            begin
                if (state.mode != MODE_IDLE)
                begin
                    priority if (item.opcode == RX_RRQ || item.opcode == RX_WRQ)
                    begin
                        state_next.mode = MODE_IDLE;
                        res_valid       = 1'b1;
                        res.send        = 1'b1;
                        res.out_opcode  = TX_ERROR;
                        res.out_block   = ERR_ILLEGAL;
                        res.out_len     = ERR_LEN;
                        res.session_end = END_ABORT;
                    end
                    else if (item.opcode == RX_DATA)
                    begin
                        if (state.mode != MODE_WRITE)
                        begin
                            state_next.mode = MODE_IDLE;
                            res_valid       = 1'b1;
                            res.send        = 1'b1;
                            res.out_opcode  = TX_ERROR;
                            res.out_block   = ERR_ILLEGAL;
                            res.out_len     = ERR_LEN;
                            res.session_end = END_ABORT;
                        end
                        else if (item.block_number == block_inc)
                        begin
                            state_next.block_count = item.block_number;
                            state_next.last_len    = HDR_LEN;
                            state_next.elapsed     = '0;
                            res_valid              = 1'b1;
                            res.send               = 1'b1;
                            res.out_opcode         = TX_ACK;
                            res.out_block          = item.block_number;
                            res.out_len            = HDR_LEN;
                            res.store_valid        = 1'b1;
                            res.store_len          = payload;
                            // A short block is the last one of the file.
                            if (payload < BLOCK_LEN)
                            begin
                                state_next.mode = MODE_IDLE;
                                res.session_end = END_DONE;
                            end
                        end
                    end
                    else if (item.opcode == RX_ACK)
                    begin
                        if (state.mode != MODE_READ)
                        begin
                            state_next.mode = MODE_IDLE;
                            res_valid       = 1'b1;
                            res.send        = 1'b1;
                            res.out_opcode  = TX_ERROR;
                            res.out_block   = ERR_ILLEGAL;
                            res.out_len     = ERR_LEN;
                            res.session_end = END_ABORT;
                        end
                        else if (item.block_number == state.block_count)
                        begin
                            res_valid = 1'b1;
                            if (state.file_ended)
                            begin
                                state_next.mode = MODE_IDLE;
                                res.session_end = END_DONE;
                            end
                            else
                            begin
                                state_next.block_count = block_inc;
                                state_next.file_ended  = (chunk_clamped < BLOCK_LEN);
                                state_next.last_len    = HDR_LEN + chunk_clamped;
                                state_next.elapsed     = '0;
                                res.send               = 1'b1;
                                res.out_opcode         = TX_DATA;
                                res.out_block          = block_inc;
                                res.out_len            = HDR_LEN + chunk_clamped;
                                res.chunk_taken        = 1'b1;
                            end
                        end
                    end
                    else if (item.opcode == RX_ERROR)
                    begin
                        state_next.mode = MODE_IDLE;
                        res_valid       = 1'b1;
                        res.session_end = END_ABORT;
                    end
                    else
                    begin
                        // Unknown opcodes leave the session as it is.
                        res_valid = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

>>> rtl/tftp_session_sequencer_core.sv
// Channel  Handshake                    Words carried
// in       in_valid / in_ready          kind, opcode, block_number, packet_len, chunk_len
// out      out_valid / out_ready        send, out_opcode, out_block, out_len,
//                                       store_valid, store_len, chunk_taken, session_end
// cfg      cfg_valid / cfg_ready        cfg_data (resend timeout, always ready)
//
// One input word per cycle is sustained while the result is not stalled; a word is held in the
// input stage register, then its result, if any, is registered in the result register.
// The session update is one pass of compare and increment logic on the stage register.
// Reset clears the session to idle and sets the resend timeout to 1000 ticks.
// A stalled result holds the stage; one more input word is still taken into an empty stage.
module tftp_session_sequencer_core
    import tss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       kind,
    input  logic [15:0]      opcode,
    input  logic [BLK_W-1:0] block_number,
    input  logic [LEN_W-1:0] packet_len,
    input  logic [LEN_W-1:0] chunk_len,

    output logic             out_valid,
    input  logic             out_ready,
    output logic             send,
    output logic [2:0]       out_opcode,
    output logic [BLK_W-1:0] out_block,
    output logic [LEN_W-1:0] out_len,
    output logic             store_valid,
    output logic [LEN_W-1:0] store_len,
    output logic             chunk_taken,
    output logic [1:0]       session_end,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [15:0]      cfg_data
);

    logic        stage_valid_reg;
    tss_item_t   stage_item_reg;
    tss_state_t  state_reg;
    tss_state_t  state_next;
    logic [15:0] timeout_reg;
    logic        out_valid_reg;
    tss_result_t out_reg;
    logic        res_valid;
    tss_result_t res;
    logic        advance;
    logic        in_fire;

    // The stage moves on when the result register is empty or being emptied.
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    tss_step u_step (
        .state      (state_reg),
        .item       (stage_item_reg),
        .timeout    (timeout_reg),
        .state_next (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '0;
            timeout_reg     <= TIMEOUT_RESET;
        end
        else
        begin
            if (in_fire)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= res_valid;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_item_reg <= '{kind: kind, opcode: opcode, block_number: block_number,
                                packet_len: packet_len, chunk_len: chunk_len};
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign send        = out_reg.send;
    assign out_opcode  = out_reg.out_opcode;
    assign out_block   = out_reg.out_block;
    assign out_len     = out_reg.out_len;
    assign store_valid = out_reg.store_valid;
    assign store_len   = out_reg.store_len;
    assign chunk_taken = out_reg.chunk_taken;
    assign session_end = out_reg.session_end;

`include "tftp_session_sequencer_core_macros.svh"

    `TSS_ASSERT_NEXT(a_stage_holds, stage_valid_reg && !advance, stage_valid_reg, "stage word lost while stalled")
    `TSS_ASSERT_NEXT(a_end_goes_idle, advance && res_valid && res.session_end != END_NONE, state_reg.mode == MODE_IDLE, "session ended but mode not idle")
    `TSS_ASSERT_SAME(a_abort_clean, out_valid_reg && out_reg.session_end == END_ABORT, !out_reg.store_valid && !out_reg.chunk_taken, "abort result carries store or chunk")

endmodule
